// ----- sv/vud_pkg.sv -----
// shared types and constants for the varint unpack decoder
package vud_pkg;

  localparam int unsigned DATA_W   = 8;
  localparam int unsigned VALUE_W  = 64;
  localparam int unsigned TOTAL_W  = 16;
  localparam int unsigned CAP_W    = 16;
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned SHIFT_W  = 7;
  localparam int unsigned GROUP_W  = 7;

  localparam logic [CAP_W-1:0] CAP_RESET = 16'hFFFF;

  // register index taken from paddr[2]
  localparam logic REG_VALUE_CAPACITY = 1'b0;

  typedef struct packed {
    logic [DATA_W-1:0] data_byte;
    logic              last_byte;
  } vud_req_t;

  typedef struct packed {
    logic               value_ready;
    logic [VALUE_W-1:0] decoded_value;
    logic               chunk_end;
    logic               status;
    logic [TOTAL_W-1:0] value_total;
  } vud_result_t;

endpackage

// ----- sv/varint_unpack_decoder_top.sv -----
// top level of the varint unpack decoder
// Decodes an unsigned LEB128-style byte stream into 64-bit values, one byte
// per cycle. A request is taken into an input register, decoded against the
// chunk state once the result register can take it and lands in the result
// register, and a new byte can be taken every cycle while the result side
// keeps up. Bytes that neither finish a value nor close a chunk give no result.
// The value capacity register sits at byte address 0 of the apb port; write
// it only while the block is idle.
module varint_unpack_decoder_top #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [vud_pkg::DATA_W-1:0]      in_data_byte,
  input  logic                            in_last_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_value_ready,
  output logic [vud_pkg::VALUE_W-1:0]     out_decoded_value,
  output logic                            out_chunk_end,
  output logic                            out_status,
  output logic [vud_pkg::TOTAL_W-1:0]     out_value_total,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [vud_pkg::PADDR_W-1:0]     paddr,
  input  logic [vud_pkg::PDATA_W-1:0]     pwdata,
  output logic [vud_pkg::PDATA_W-1:0]     prdata,
  output logic                            pready
);

  logic                      in_v_r, in_v_nxt;
  vud_pkg::vud_req_t         req_r, req_nxt;
  logic                      in_accept;
  logic                      req_take;
  logic [vud_pkg::CAP_W-1:0] value_capacity;
  vud_pkg::vud_result_t      res;

  assign in_stall  = in_v_r && !req_take;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    in_v_nxt = in_v_r;
    req_nxt  = req_r;
    if (in_accept) begin
      in_v_nxt          = 1'b1;
      req_nxt.data_byte = in_data_byte;
      req_nxt.last_byte = in_last_byte;
    end else if (req_take) begin
      in_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
  end

  vud_cfg u_cfg (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .value_capacity (value_capacity)
  );

  vud_decode #(
    .COUNT_BITS (COUNT_BITS)
  ) u_decode (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (in_v_r),
    .req            (req_r),
    .req_take       (req_take),
    .value_capacity (value_capacity),
    .res_valid      (out_valid),
    .res            (res),
    .res_stall      (out_stall)
  );

  assign out_value_ready   = res.value_ready;
  assign out_decoded_value = res.decoded_value;
  assign out_chunk_end     = res.chunk_end;
  assign out_status        = res.status;
  assign out_value_total   = res.value_total;

endmodule

// ----- sv/vud_cfg.sv -----
// apb register block holding the value capacity
module vud_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [vud_pkg::PADDR_W-1:0]     paddr,
  input  logic [vud_pkg::PDATA_W-1:0]     pwdata,
  output logic [vud_pkg::PDATA_W-1:0]     prdata,
  output logic                            pready,
  output logic [vud_pkg::CAP_W-1:0]       value_capacity
);

  logic [vud_pkg::CAP_W-1:0] cap_r;
  logic [vud_pkg::CAP_W-1:0] cap_nxt;
  logic                      sel_cap;

  assign sel_cap = (paddr[2] == vud_pkg::REG_VALUE_CAPACITY);

  always_comb begin
    cap_nxt = cap_r;
    if (psel && penable && pwrite && sel_cap) begin
      cap_nxt = pwdata[vud_pkg::CAP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= vud_pkg::CAP_RESET;
    end else begin
      cap_r <= cap_nxt;
    end
  end

  assign prdata         = sel_cap ? vud_pkg::PDATA_W'(cap_r) : '0;
  assign pready         = 1'b1;
  assign value_capacity = cap_r;

endmodule

// ----- sv/vud_decode.sv -----
// decode stage: chunk state, byte gathering and the result register
module vud_decode #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          req_valid,
  input  vud_pkg::vud_req_t             req,
  output logic                          req_take,
  input  logic [vud_pkg::CAP_W-1:0]     value_capacity,
  output logic                          res_valid,
  output vud_pkg::vud_result_t          res,
  input  logic                          res_stall
);

  localparam int unsigned CMP_W = (COUNT_BITS > vud_pkg::CAP_W) ? COUNT_BITS : vud_pkg::CAP_W;

  logic [vud_pkg::VALUE_W-1:0] acc_r, acc_nxt;
  logic [vud_pkg::POS_W-1:0]   pos_r, pos_nxt;
  logic [COUNT_BITS-1:0]       seen_r, seen_nxt;
  logic                        err_r, err_nxt;
  logic                        res_valid_r, res_valid_nxt;
  vud_pkg::vud_result_t        res_r, res_nxt;

  logic [vud_pkg::SHIFT_W-1:0] shift;
  logic [vud_pkg::VALUE_W-1:0] group;
  logic [vud_pkg::VALUE_W-1:0] top_byte;
  logic [vud_pkg::VALUE_W-1:0] acc_new;
  logic                        ninth;
  logic                        done;
  logic                        over;
  logic [CMP_W-1:0]            seen_ext;
  logic [CMP_W-1:0]            seen_inc_ext;
  logic [COUNT_BITS-1:0]       seen_inc;

  assign req_take = req_valid && (!res_valid_r || !res_stall);

  // 7 * position, as 8p - p
  assign shift    = {pos_r, 3'b000} - {3'b000, pos_r};
  assign group    = vud_pkg::VALUE_W'(req.data_byte[vud_pkg::GROUP_W-1:0]) << shift;
  assign ninth    = pos_r[3];
  assign top_byte = ninth ? {req.data_byte, {(vud_pkg::VALUE_W-vud_pkg::DATA_W){1'b0}}} : '0;
  assign acc_new  = acc_r | group | top_byte;
  assign done     = ninth || !req.data_byte[vud_pkg::DATA_W-1];

  assign seen_inc     = seen_r + 1'b1;
  assign seen_ext     = CMP_W'(seen_r);
  assign seen_inc_ext = CMP_W'(seen_inc);
  assign over         = (seen_ext >= CMP_W'(value_capacity)) || (&seen_r);

  always_comb begin
    acc_nxt       = acc_r;
    pos_nxt       = pos_r;
    seen_nxt      = seen_r;
    err_nxt       = err_r;
    res_nxt       = res_r;
    res_valid_nxt = res_valid_r && res_stall;

    if (req_take) begin
      res_nxt.value_ready   = 1'b0;
      res_nxt.decoded_value = '0;
      res_nxt.chunk_end     = req.last_byte;
      res_nxt.status        = 1'b1;
      res_nxt.value_total   = seen_ext[vud_pkg::TOTAL_W-1:0];
      priority if (err_r) begin
        res_valid_nxt = req.last_byte;
      end else if (done) begin
        acc_nxt       = '0;
        pos_nxt       = '0;
        res_valid_nxt = 1'b1;
        if (over) begin
          err_nxt = 1'b1;
        end else begin
          seen_nxt              = seen_inc;
          res_nxt.value_ready   = 1'b1;
          res_nxt.decoded_value = acc_new;
          res_nxt.status        = 1'b0;
          res_nxt.value_total   = seen_inc_ext[vud_pkg::TOTAL_W-1:0];
        end
      end else if (req.last_byte) begin
        res_valid_nxt = 1'b1;
      end else begin
        acc_nxt = acc_new;
        pos_nxt = pos_r + 1'b1;
      end
      // chunk close clears everything
      if (req.last_byte) begin
        acc_nxt  = '0;
        pos_nxt  = '0;
        seen_nxt = '0;
        err_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      pos_r       <= '0;
      seen_r      <= '0;
      err_r       <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      pos_r       <= pos_nxt;
      seen_r      <= seen_nxt;
      err_r       <= err_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

// ----- sv/vud_checker.sv -----
// port-level checks for the varint unpack decoder, bound to the top level
module vud_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic                        out_value_ready,
  input logic [vud_pkg::VALUE_W-1:0] out_decoded_value,
  input logic                        out_chunk_end,
  input logic                        out_status,
  input logic [vud_pkg::TOTAL_W-1:0] out_value_total
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_decoded_value)
      && $stable(out_value_total) && $stable(out_status))
    else $error("stalled result changed");

  // a result without a value is always an error report
  a_novalue_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_value_ready |-> out_status && (out_decoded_value == '0))
    else $error("result without value is not an error");

  // a delivered value is counted and clean
  a_value_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_value_ready |-> !out_status && (out_value_total != '0))
    else $error("value result has bad status or count");

  // a non-final error ends decoding for the chunk: next result closes it
  a_after_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_status && !out_chunk_end
      |=> !out_valid || out_stall || out_chunk_end || !$past(out_valid))
    else $error("result after mid-chunk error does not close chunk");

endmodule

bind varint_unpack_decoder_top vud_checker u_vud_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_value_ready   (out_value_ready),
  .out_decoded_value (out_decoded_value),
  .out_chunk_end     (out_chunk_end),
  .out_status        (out_status),
  .out_value_total   (out_value_total)
);

// ----- test/varint_unpack_decoder_top_tb.sv -----
// testbench for the varint unpack decoder: random and directed byte streams against a predictor
module varint_unpack_decoder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned COUNT_BITS  = 16;
  localparam int unsigned COUNT_MAX   = (1 << COUNT_BITS) - 1;
  localparam int unsigned RUN_LIMIT   = 1000000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned SETTLE      = 8;
  localparam int unsigned SHOW_MAX    = 10;
  localparam logic [vud_pkg::PADDR_W-1:0] CAP_ADDR = {vud_pkg::REG_VALUE_CAPACITY, 2'b00};

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [vud_pkg::DATA_W-1:0]   in_data_byte = '0;
  logic                         in_last_byte = 1'b0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic                         out_value_ready;
  logic [vud_pkg::VALUE_W-1:0]  out_decoded_value;
  logic                         out_chunk_end;
  logic                         out_status;
  logic [vud_pkg::TOTAL_W-1:0]  out_value_total;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [vud_pkg::PADDR_W-1:0]  paddr = '0;
  logic [vud_pkg::PDATA_W-1:0]  pwdata = '0;
  logic [vud_pkg::PDATA_W-1:0]  prdata;
  logic                         pready;

  varint_unpack_decoder_top #(
    .COUNT_BITS(COUNT_BITS)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_value_ready  (out_value_ready),
    .out_decoded_value(out_decoded_value),
    .out_chunk_end    (out_chunk_end),
    .out_status       (out_status),
    .out_value_total  (out_value_total),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  vud_pkg::vud_req_t    coded_bytes[$];
  vud_pkg::vud_result_t pending_results[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_req = 1'b0;
  int unsigned hold_left = 0;
  bit          in_fire = 1'b0;

  int unsigned mismatches = 0;
  int unsigned bytes_taken = 0;
  int unsigned results_checked = 0;
  int unsigned chunks_closed = 0;
  int unsigned values_checked = 0;
  int unsigned format_errors = 0;

  // predictor state
  logic [vud_pkg::VALUE_W-1:0] acc_value = '0;
  int unsigned                 group_pos = 0;
  logic [vud_pkg::TOTAL_W-1:0] chunk_values = '0;
  bit                          chunk_failed = 1'b0;
  logic [vud_pkg::CAP_W-1:0]   capacity = vud_pkg::CAP_RESET;

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (RUN_LIMIT) @(posedge clk);
    $display("run stopped at the cycle limit after %0d requests and %0d results",
             bytes_taken, results_checked);
    $display("Mismatches found");
    $finish;
  end

  function automatic void clear_chunk_state();
    acc_value    = '0;
    group_pos    = 0;
    chunk_values = '0;
    chunk_failed = 1'b0;
  endfunction

  function automatic void decode_byte(logic [vud_pkg::DATA_W-1:0] b, logic last);
    vud_pkg::vud_result_t        r;
    logic                        done;
    logic [vud_pkg::VALUE_W-1:0] v;
    r = '0;
    if (chunk_failed) begin
      if (last) begin
        r.chunk_end   = 1'b1;
        r.status      = 1'b1;
        r.value_total = chunk_values;
        pending_results.push_back(r);
        clear_chunk_state();
      end
      return;
    end
    if (group_pos > 8) group_pos = 8;
    acc_value = acc_value | ({57'd0, b[6:0]} << (vud_pkg::GROUP_W * group_pos));
    group_pos = group_pos + 1;
    done = ~b[7];
    // ninth byte fills the top eight bits and always closes the value
    if (group_pos == 9) begin
      acc_value = acc_value | ({56'd0, b} << 56);
      done = 1'b1;
    end
    if (done) begin
      v = acc_value;
      acc_value = '0;
      group_pos = 0;
      r.chunk_end = last;
      if (chunk_values >= capacity || chunk_values >= COUNT_MAX) begin
        r.status      = 1'b1;
        r.value_total = chunk_values;
        if (last) clear_chunk_state();
        else chunk_failed = 1'b1;
      end else begin
        chunk_values    = chunk_values + 1'b1;
        r.value_ready   = 1'b1;
        r.decoded_value = v;
        r.value_total   = chunk_values;
        if (last) clear_chunk_state();
      end
      pending_results.push_back(r);
    end else if (last) begin
      r.chunk_end   = 1'b1;
      r.status      = 1'b1;
      r.value_total = chunk_values;
      pending_results.push_back(r);
      clear_chunk_state();
    end
  endfunction

  // request driver
  always @(negedge clk) begin
    vud_pkg::vud_req_t req;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (coded_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        req = coded_bytes.pop_front();
        in_valid     <= 1'b1;
        in_data_byte <= req.data_byte;
        in_last_byte <= req.last_byte;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (hold_req) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // monitor
  always @(posedge clk) begin
    vud_pkg::vud_result_t got;
    vud_pkg::vud_result_t want;
    in_fire <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      decode_byte(in_data_byte, in_last_byte);
      bytes_taken++;
    end
    if (rst_n && out_valid && !out_stall) begin
      got.value_ready   = out_value_ready;
      got.decoded_value = out_decoded_value;
      got.chunk_end     = out_chunk_end;
      got.status        = out_status;
      got.value_total   = out_value_total;
      results_checked++;
      if (got.chunk_end) chunks_closed++;
      if (got.value_ready) values_checked++;
      if (got.status) format_errors++;
      if (pending_results.size() == 0) begin
        if (mismatches < SHOW_MAX)
          $display("unexpected result: ready=%0b value=%h end=%0b status=%0b total=%0d",
                   got.value_ready, got.decoded_value, got.chunk_end, got.status,
                   got.value_total);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          if (mismatches < SHOW_MAX) begin
            $display("mismatch: expected ready=%0b value=%h end=%0b status=%0b total=%0d",
                     want.value_ready, want.decoded_value, want.chunk_end, want.status,
                     want.value_total);
            $display("          actual   ready=%0b value=%h end=%0b status=%0b total=%0d",
                     got.value_ready, got.decoded_value, got.chunk_end, got.status,
                     got.value_total);
          end
          mismatches++;
        end
      end
    end
  end

  task automatic drain();
    while (coded_bytes.size() != 0 || in_valid || pending_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_capacity(logic [vud_pkg::CAP_W-1:0] cap_val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= CAP_ADDR;
    pwdata  <= {16'($urandom_range(0, 65535)), cap_val};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    capacity = cap_val;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic void push_byte(logic [vud_pkg::DATA_W-1:0] b, logic last);
    vud_pkg::vud_req_t req;
    req.data_byte = b;
    req.last_byte = last;
    coded_bytes.push_back(req);
  endfunction

  function automatic void push_value(int unsigned len, bit close_chunk);
    logic [vud_pkg::DATA_W-1:0] b;
    for (int unsigned i = 0; i < len; i++) begin
      b = 8'($urandom_range(0, 255));
      if (i < len - 1) b[7] = 1'b1;
      else if (len < 9) b[7] = 1'b0;
      push_byte(b, close_chunk && (i == len - 1));
    end
  endfunction

  function automatic int unsigned pick_len();
    if ($urandom_range(0, 3) == 0) return $urandom_range(1, 9);
    return $urandom_range(1, 3);
  endfunction

  function automatic void push_random_chunk();
    int unsigned kind;
    int unsigned nv;
    int unsigned n;
    kind = $urandom_range(0, 9);
    nv   = $urandom_range(1, 5);
    if (kind <= 6) begin
      for (int unsigned k = 0; k < nv; k++) push_value(pick_len(), k == nv - 1);
    end else if (kind == 7) begin
      // partial value left open at chunk end
      for (int unsigned k = 0; k < nv; k++) push_value(pick_len(), 1'b0);
      n = $urandom_range(1, 8);
      for (int unsigned i = 0; i < n; i++)
        push_byte({1'b1, 7'($urandom_range(0, 127))}, i == n - 1);
    end else if (kind == 8) begin
      n = $urandom_range(1, 12);
      for (int unsigned i = 0; i < n; i++) push_byte(8'($urandom_range(0, 255)), i == n - 1);
    end else begin
      push_byte(8'($urandom_range(0, 255)), 1'b1);
    end
  endfunction

  function automatic logic [vud_pkg::CAP_W-1:0] pick_capacity();
    case ($urandom_range(0, 6))
      0: return '0;
      1: return 16'd1;
      2: return 16'd2;
      3: return 16'd3;
      4: return 16'd5;
      5: return vud_pkg::CAP_RESET;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  initial begin
    int unsigned target;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset capacity, extremes, ninth byte, partial end
    push_byte(8'h00, 1'b1);
    push_byte(8'h7f, 1'b1);
    for (int i = 0; i < 8; i++) push_byte(8'hff, 1'b0);
    push_byte(8'hff, 1'b1);
    for (int i = 0; i < 8; i++) push_byte(8'h80, 1'b0);
    push_byte(8'h00, 1'b1);
    push_byte(8'h80, 1'b1);
    push_byte(8'h05, 1'b0);
    push_byte(8'h81, 1'b0);
    push_byte(8'h01, 1'b1);
    drain();
    // capacity zero: error at once, later bytes dropped, error on last byte too
    write_capacity('0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h82, 1'b0);
    push_byte(8'h03, 1'b1);
    push_byte(8'h04, 1'b1);
    drain();
    write_capacity(16'd1);
    push_byte(8'h01, 1'b0);
    push_byte(8'h02, 1'b1);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      for (int seg = 0; seg < 3; seg++) begin
        drain();
        write_capacity(pick_capacity());
        target = coded_bytes.size() + 72;
        while (coded_bytes.size() < target) push_random_chunk();
        if (ph == 0 && seg == 0) begin
          // long receiver hold-off while the sender keeps offering requests
          hold_req = 1'b1;
          @(negedge clk);
          hold_req = 1'b0;
        end
      end
    end
    drain();

    if (pending_results.size() != 0) mismatches++;
    $display("run covered %0d requests and %0d results: %0d values, %0d closed chunks",
             bytes_taken, results_checked, values_checked, chunks_closed);
    $display("%0d illegal-format results over several capacity settings and idle patterns",
             format_errors);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
